// File: design/rtfx_pkg.sv
`default_nettype none
package rtfx_pkg;

	localparam int STACK_DEPTH   = 32;
	localparam int KEYWORD_BYTES = 11;
	localparam int SD_W          = $clog2(STACK_DEPTH);
	localparam int DEP_W         = $clog2(STACK_DEPTH + 1);
	localparam int KW_BITS       = 8 * KEYWORD_BYTES;
	localparam int KLEN_W        = $clog2(KEYWORD_BYTES + 1);
	localparam int Q_DEPTH       = 4;
	localparam int QP_W          = $clog2(Q_DEPTH);
	localparam int QC_W          = $clog2(Q_DEPTH + 1);

	localparam logic [2:0] ST_TEXT     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_EOF_ESC  = 3'd2;
	localparam logic [2:0] ST_BAD_HEX  = 3'd3;
	localparam logic [2:0] ST_XCLOSE   = 3'd4;
	localparam logic [2:0] ST_UNCLOSED = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	localparam logic [2:0] LX_IDLE  = 3'd0;
	localparam logic [2:0] LX_ESC   = 3'd1;
	localparam logic [2:0] LX_WORD  = 3'd2;
	localparam logic [2:0] LX_MINUS = 3'd3;
	localparam logic [2:0] LX_DIGIT = 3'd4;

	localparam logic [1:0] PM_NORMAL = 2'd0;
	localparam logic [1:0] PM_HEX    = 2'd1;
	localparam logic [1:0] PM_BIN    = 2'd2;

	localparam logic [1:0] KD_NONE = 2'd0;
	localparam logic [1:0] KD_CHAR = 2'd1;
	localparam logic [1:0] KD_DEST = 2'd2;
	localparam logic [1:0] KD_BIN  = 2'd3;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef struct packed {
		logic [7:0] b;
		logic [2:0] st;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]      n;
		res_t [2:0]      ent;
	} push_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} kw_t;

	function automatic kw_t kw_find(input logic [KW_BITS-1:0] w);
		kw_t r;
		r.kind = KD_NONE;
		r.ch   = 8'h00;
		case (w)
			"par", "tab": begin
				r.kind = KD_CHAR;
				r.ch   = CH_LF;
			end
			"ldblquote", "rdblquote": begin
				r.kind = KD_CHAR;
				r.ch   = 8'h22;
			end
			"lquote", "rquote": begin
				r.kind = KD_CHAR;
				r.ch   = 8'h27;
			end
			"bin": r.kind = KD_BIN;
			"author", "buptim", "colortbl", "comment", "creatim", "doccomm",
			"fonttbl", "footer", "footerf", "footerl", "footerr", "footnote",
			"ftncn", "ftnsep", "ftnsepc", "header", "headerf", "headerl",
			"headerr", "info", "keywords", "operator", "pict", "printim",
			"private1", "revtim", "rxe", "stylesheet", "subject", "tc",
			"title", "txe", "xe": r.kind = KD_DEST;
			default: r.kind = KD_NONE;
		endcase
		return r;
	endfunction

	// largest value that can take another digit d without passing 2^31-1
	function automatic logic [30:0] dig_lim(input logic [3:0] d);
		logic [30:0] r;
		case (d)
			4'd0: r = 31'((32'h7fffffff - 0) / 10);
			4'd1: r = 31'((32'h7fffffff - 1) / 10);
			4'd2: r = 31'((32'h7fffffff - 2) / 10);
			4'd3: r = 31'((32'h7fffffff - 3) / 10);
			4'd4: r = 31'((32'h7fffffff - 4) / 10);
			4'd5: r = 31'((32'h7fffffff - 5) / 10);
			4'd6: r = 31'((32'h7fffffff - 6) / 10);
			4'd7: r = 31'((32'h7fffffff - 7) / 10);
			4'd8: r = 31'((32'h7fffffff - 8) / 10);
			default: r = 31'((32'h7fffffff - 9) / 10);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/rtfx_rq.sv
`default_nettype none
module rtfx_rq (
	input  wire                    clk,
	input  wire                    arst_n,
	input  rtfx_pkg::push_t        push,
	input  wire                    pop,
	output rtfx_pkg::res_t         head,
	output logic [rtfx_pkg::QC_W-1:0] count
);
	import rtfx_pkg::*;

	res_t            mem_q [Q_DEPTH];
	logic [QP_W-1:0] wp_q;
	logic [QP_W-1:0] rp_q;
	logic [QC_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push.n) begin
				mem_q[wp_q + QP_W'(i)] <= push.ent[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QP_W'(push.n);
			rp_q  <= rp_q + QP_W'(pop);
			cnt_q <= cnt_q + QC_W'(push.n) - QC_W'(pop);
		end
	end

	assign head  = mem_q[rp_q];
	assign count = cnt_q;

`ifndef NO_ASSERTIONS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(Q_DEPTH)) else $error("result queue overrun");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == QC_W'(Q_DEPTH)) |-> wp_q == rp_q)
		else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// File: design/rtf_plain_text_extractor.sv
// pipeline: input byte registered in s1, results written to the result queue
// throughput: one input byte per cycle while out_stall is low and each byte gives
//   at most one result; input stalls while the 4-entry result queue holds over one entry
// reset: arst_n asynchronous active low clears parser state, group depth and queue;
//   the group stack and keyword bytes are not cleared
`default_nettype none
module rtf_plain_text_extractor (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	input  wire        doc_end,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);
	import rtfx_pkg::*;

	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;

	logic              stack_q [STACK_DEPTH];
	logic [DEP_W-1:0]  depth_q;
	logic              skip_q;
	logic [1:0]        mode_q;
	logic [30:0]       pend_q;
	logic [7:0]        hex_q;
	logic              sunk_q;
	logic [2:0]        lex_q;
	logic [KW_BITS-1:0] chars_q;
	logic [KLEN_W-1:0] klen_q;
	logic [30:0]       pv_q;
	logic              neg_q;
	logic              hasp_q;
	logic              err_q;

	logic              can_proc;
	logic              fire;
	logic              in_acc;
	logic [QC_W-1:0]   qcount;
	res_t              qhead;
	push_t             push;

	logic [DEP_W-1:0]  depth_n;
	logic              skip_n;
	logic [1:0]        mode_n;
	logic [30:0]       pend_n;
	logic [7:0]        hex_n;
	logic              sunk_n;
	logic [2:0]        lex_n;
	logic [KW_BITS-1:0] chars_n;
	logic [KLEN_W-1:0] klen_n;
	logic [30:0]       pv_n;
	logic              neg_n;
	logic              hasp_n;
	logic              err_n;
	logic              st_wr;
	logic [SD_W-1:0]   st_idx;
	logic              st_val;
	logic [SD_W-1:0]   rd_idx;

	assign can_proc = qcount <= QC_W'(Q_DEPTH - 3);
	assign fire     = v_s1 && can_proc;
	assign in_stall = v_s1 && !can_proc;
	assign in_acc   = in_valid && !in_stall;
	assign rd_idx   = SD_W'(depth_q - DEP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			end_s1  <= doc_end;
		end
		if (st_wr) begin
			stack_q[st_idx] <= st_val;
		end
		chars_q <= chars_n;
	end

	always_comb begin
		logic [7:0] c;
		logic       e;
		logic       ok;
		logic       clr;
		logic       sym;
		logic       do_word;
		logic       do_plain;
		logic       alpha;
		logic       digit;
		logic [3:0] d;
		logic [3:0] hv;
		logic       hok;
		logic [30:0] pv10;
		kw_t        kw;
		logic [1:0] n;
		res_t [2:0] ent;

		c = byte_s1;
		e = end_s1;
		ok = 1'b1;
		clr = 1'b0;
		sym = 1'b0;
		do_word = 1'b0;
		do_plain = 1'b0;
		n = 2'd0;
		ent = '0;
		alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		digit = c >= "0" && c <= "9";
		d = 4'(c - "0");
		pv10 = 31'({pv_q, 3'b000} + {pv_q, 1'b0}) + 31'(d);
		hv = 4'd0;
		hok = 1'b1;
		kw = '0;

		depth_n = depth_q; skip_n = skip_q; mode_n = mode_q; pend_n = pend_q;
		hex_n = hex_q; sunk_n = sunk_q; lex_n = lex_q; chars_n = chars_q;
		klen_n = klen_q; pv_n = pv_q; neg_n = neg_q; hasp_n = hasp_q; err_n = err_q;
		st_wr = 1'b0;
		st_idx = SD_W'(depth_q);
		st_val = skip_q;

		if (fire) begin
			if (err_q) begin
				clr = e;
			end else begin
				case (lex_q)
					LX_ESC: begin
						if (alpha) begin
							chars_n = KW_BITS'(c);
							klen_n = KLEN_W'(1);
							pv_n = '0; neg_n = 1'b0; hasp_n = 1'b0;
							lex_n = LX_WORD;
						end else begin
							lex_n = LX_IDLE;
							sym = 1'b1;
						end
					end
					LX_WORD: begin
						if (alpha) begin
							if (klen_q < KLEN_W'(KEYWORD_BYTES)) begin
								chars_n = {chars_q[KW_BITS-9:0], c};
								klen_n = klen_q + KLEN_W'(1);
							end
						end else if (c == "-") begin
							neg_n = 1'b1;
							lex_n = LX_MINUS;
						end else if (digit) begin
							pv_n = (pv_q > dig_lim(d)) ? 31'h7fffffff : pv10;
							hasp_n = 1'b1;
							lex_n = LX_DIGIT;
						end else begin
							do_word = 1'b1;
							do_plain = c != " ";
						end
					end
					LX_MINUS, LX_DIGIT: begin
						if (digit) begin
							pv_n = (pv_q > dig_lim(d)) ? 31'h7fffffff : pv10;
							hasp_n = 1'b1;
							lex_n = LX_DIGIT;
						end else begin
							do_word = 1'b1;
							do_plain = c != " ";
						end
					end
					default: begin
						lex_n = LX_IDLE;
						do_plain = 1'b1;
					end
				endcase
				if (e && lex_n >= LX_WORD) begin
					do_word = 1'b1;
				end

				if (sym) begin
					if (c == "{" || c == "}" || c == "\\" || c == CH_CR || c == CH_LF) begin
						sunk_n = 1'b0;
						if (!skip_n) begin
							ent[n] = '{(c == CH_CR) ? CH_LF : c, ST_TEXT, 1'b0};
							n = n + 2'd1;
						end
					end else if (c == "*") begin
						sunk_n = 1'b1;
					end else if (c == "'") begin
						sunk_n = 1'b0;
						mode_n = PM_HEX;
						pend_n = 31'd2;
					end else begin
						if (sunk_n) skip_n = 1'b1;
						sunk_n = 1'b0;
					end
				end

				if (do_word) begin
					lex_n = LX_IDLE;
					kw = kw_find(chars_n);
					if (klen_n >= KLEN_W'(KEYWORD_BYTES) || kw.kind == KD_NONE) begin
						if (sunk_n) skip_n = 1'b1;
						sunk_n = 1'b0;
					end else begin
						sunk_n = 1'b0;
						case (kw.kind)
							KD_CHAR: begin
								if (!skip_n) begin
									ent[n] = '{kw.ch, ST_TEXT, 1'b0};
									n = n + 2'd1;
								end
							end
							KD_DEST: skip_n = 1'b1;
							default: begin
								if (hasp_n && !neg_n && pv_n != '0) begin
									mode_n = PM_BIN;
									pend_n = pv_n;
								end
							end
						endcase
					end
				end

				if (do_plain) begin
					if (mode_n == PM_BIN) begin
						pend_n = pend_n - 31'd1;
						if (pend_n == '0) mode_n = PM_NORMAL;
						if (!skip_n) begin
							ent[n] = '{c, ST_TEXT, 1'b0};
							n = n + 2'd1;
						end
					end else if (c == "{") begin
						if (depth_q >= DEP_W'(STACK_DEPTH)) begin
							ok = 1'b0;
							ent[n] = '{8'h00, ST_OVERFLOW, 1'b1};
							n = n + 2'd1;
						end else begin
							st_wr = 1'b1;
							st_val = skip_n;
							depth_n = depth_q + DEP_W'(1);
							mode_n = PM_NORMAL;
						end
					end else if (c == "}") begin
						if (depth_q == '0) begin
							ok = 1'b0;
							ent[n] = '{8'h00, ST_XCLOSE, 1'b1};
							n = n + 2'd1;
						end else begin
							depth_n = depth_q - DEP_W'(1);
							skip_n = stack_q[rd_idx];
							mode_n = PM_NORMAL;
						end
					end else if (c == "\\") begin
						if (e) begin
							ok = 1'b0;
							ent[n] = '{8'h00, ST_EOF_ESC, 1'b1};
							n = n + 2'd1;
						end else begin
							lex_n = LX_ESC;
						end
					end else if (c == CH_CR || c == CH_LF) begin
						ok = 1'b1;
					end else if (mode_n == PM_HEX) begin
						if (digit) hv = d;
						else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
						else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
						else hok = 1'b0;
						if (!hok) begin
							ok = 1'b0;
							ent[n] = '{8'h00, ST_BAD_HEX, 1'b1};
							n = n + 2'd1;
						end else begin
							hex_n = {hex_q[3:0], hv};
							pend_n = pend_n - 31'd1;
							if (pend_n == '0) begin
								mode_n = PM_NORMAL;
								if (!skip_n) begin
									ent[n] = '{hex_n, ST_TEXT, 1'b0};
									n = n + 2'd1;
								end
							end
						end
					end else if (!skip_n) begin
						ent[n] = '{c, ST_TEXT, 1'b0};
						n = n + 2'd1;
					end
				end

				if (!ok) err_n = 1'b1;
				if (e) begin
					if (ok) begin
						ent[n] = '{8'h00, (depth_n != '0) ? ST_UNCLOSED : ST_DONE, 1'b1};
						n = n + 2'd1;
					end
					clr = 1'b1;
				end
			end
		end

		if (clr) begin
			depth_n = '0; skip_n = 1'b0; mode_n = PM_NORMAL; pend_n = '0; hex_n = '0;
			sunk_n = 1'b0; lex_n = LX_IDLE; klen_n = '0; pv_n = '0; neg_n = 1'b0;
			hasp_n = 1'b0; err_n = 1'b0;
		end
		push.n = n;
		push.ent = ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			skip_q  <= 1'b0;
			mode_q  <= PM_NORMAL;
			pend_q  <= '0;
			hex_q   <= '0;
			sunk_q  <= 1'b0;
			lex_q   <= LX_IDLE;
			klen_q  <= '0;
			pv_q    <= '0;
			neg_q   <= 1'b0;
			hasp_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			depth_q <= depth_n;
			skip_q  <= skip_n;
			mode_q  <= mode_n;
			pend_q  <= pend_n;
			hex_q   <= hex_n;
			sunk_q  <= sunk_n;
			lex_q   <= lex_n;
			klen_q  <= klen_n;
			pv_q    <= pv_n;
			neg_q   <= neg_n;
			hasp_q  <= hasp_n;
			err_q   <= err_n;
		end
	end

	rtfx_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_valid && !out_stall),
		.head   (qhead),
		.count  (qcount)
	);

	assign out_valid = qcount != '0;
	assign out_byte  = qhead.b;
	assign status    = qhead.st;
	assign last      = qhead.last;

`ifndef NO_ASSERTIONS
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEP_W'(STACK_DEPTH)) else $error("group depth beyond stack");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_TEXT |-> last) else $error("status beat without last");
	a_text_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_TEXT |-> out_byte == 8'h00)
		else $error("status beat carries a byte");
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && err_q |-> push.n == 2'd0) else $error("result after latched error");
`endif

endmodule
`default_nettype wire

// File: verif/rtf_plain_text_extractor_tb.sv
`timescale 1ns / 1ps
module rtf_plain_text_extractor_tb;
	import rtfx_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic [2:0] st;
		logic       last;
	} text_beat_t;

	class rtf_text_board;
		int unsigned errors;
		text_beat_t expected_text[$];
		// parser state
		bit [STACK_DEPTH-1:0] grp_skip;
		int unsigned depth;
		bit skip_text, star_flag, err_latched;
		bit [1:0] mode;
		bit [2:0] lex;
		int unsigned pending;
		bit [7:0] hex_acc;
		byte unsigned word[$];
		int unsigned wlen;
		bit [31:0] pval;
		bit pneg, has_p;
		int nres;

		function void clear();
			depth = 0; skip_text = 0; star_flag = 0; err_latched = 0;
			mode = PM_NORMAL; lex = LX_IDLE; pending = 0; hex_acc = 0;
			word.delete(); wlen = 0; pval = 0; pneg = 0; has_p = 0;
		endfunction

		function void emit(bit [7:0] b, bit [2:0] st, bit l);
			text_beat_t t;
			if (nres >= 3) return;
			t.b = b; t.st = st; t.last = l;
			expected_text = {expected_text, t};
			nres++;
		endfunction

		function void txt(bit [7:0] c);
			if (!skip_text) emit(c, ST_TEXT, 0);
		endfunction

		function bit raise(bit [2:0] code);
			emit(8'h00, code, 1);
			err_latched = 1;
			return 0;
		endfunction

		function void unknown();
			if (star_flag) skip_text = 1;
			star_flag = 0;
		endfunction

		function void symbol(bit [7:0] c);
			if (c == "{" || c == "}" || c == "\\") begin
				star_flag = 0; txt(c);
			end else if (c == CH_LF || c == CH_CR) begin
				star_flag = 0; txt(CH_LF);
			end else if (c == "*") begin
				star_flag = 1;
			end else if (c == "'") begin
				star_flag = 0; mode = PM_HEX; pending = 2;
			end else begin
				unknown();
			end
		endfunction

		function void run_word();
			string s;
			bit sf;
			lex = LX_IDLE;
			if (wlen >= KEYWORD_BYTES) begin
				unknown();
				return;
			end
			s = "";
			foreach (word[i]) s = {s, string'(word[i])};
			sf = star_flag;
			star_flag = 0;
			case (s)
				"par", "tab": txt(CH_LF);
				"ldblquote", "rdblquote": txt(8'h22);
				"lquote", "rquote": txt(8'h27);
				"bin": if (has_p && !pneg && pval > 0) begin
					mode = PM_BIN; pending = pval;
				end
				"author", "buptim", "colortbl", "comment", "creatim", "doccomm",
				"fonttbl", "footer", "footerf", "footerl", "footerr", "footnote",
				"ftncn", "ftnsep", "ftnsepc", "header", "headerf", "headerl",
				"headerr", "info", "keywords", "operator", "pict", "printim",
				"private1", "revtim", "rxe", "stylesheet", "subject", "tc",
				"title", "txe", "xe": skip_text = 1;
				default: begin
					star_flag = sf;
					unknown();
				end
			endcase
		endfunction

		function void digit(bit [7:0] c);
			bit [31:0] d;
			d = c - "0";
			if (pval > (32'h7fffffff - d) / 10) pval = 32'h7fffffff;
			else pval = pval * 10 + d;
			has_p = 1;
			lex = LX_DIGIT;
		endfunction

		function bit plain(bit [7:0] c, bit fin);
			bit [3:0] v;
			if (mode == PM_BIN) begin
				pending--;
				if (pending == 0) mode = PM_NORMAL;
				txt(c);
				return 1;
			end
			if (c == "{") begin
				if (depth >= STACK_DEPTH) return raise(ST_OVERFLOW);
				grp_skip[depth] = skip_text;
				depth++;
				mode = PM_NORMAL;
			end else if (c == "}") begin
				if (depth == 0) return raise(ST_XCLOSE);
				depth--;
				skip_text = grp_skip[depth];
				mode = PM_NORMAL;
			end else if (c == "\\") begin
				if (fin) return raise(ST_EOF_ESC);
				lex = LX_ESC;
			end else if (c == CH_CR || c == CH_LF) begin
			end else if (mode == PM_HEX) begin
				if (c >= "0" && c <= "9") v = c - "0";
				else if (c >= "a" && c <= "f") v = c - "a" + 10;
				else if (c >= "A" && c <= "F") v = c - "A" + 10;
				else return raise(ST_BAD_HEX);
				hex_acc = {hex_acc[3:0], v};
				pending--;
				if (pending == 0) begin
					mode = PM_NORMAL; txt(hex_acc);
				end
			end else begin
				txt(c);
			end
			return 1;
		endfunction

		function bit alpha(bit [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function void note_byte(bit [7:0] c, bit fin);
			bit ok;
			ok = 1;
			nres = 0;
			if (err_latched) begin
				if (fin) clear();
				return;
			end
			case (lex)
				LX_ESC: if (alpha(c)) begin
					word.delete(); word = {word, c}; wlen = 1;
					pval = 0; pneg = 0; has_p = 0; lex = LX_WORD;
				end else begin
					lex = LX_IDLE; symbol(c);
				end
				LX_WORD: if (alpha(c)) begin
					if (wlen < KEYWORD_BYTES) begin
						word = {word, c}; wlen++;
					end
				end else if (c == "-") begin
					pneg = 1; lex = LX_MINUS;
				end else if (c >= "0" && c <= "9") begin
					digit(c);
				end else begin
					run_word();
					if (c != " ") ok = plain(c, fin);
				end
				LX_MINUS, LX_DIGIT: if (c >= "0" && c <= "9") digit(c);
				else begin
					run_word();
					if (c != " ") ok = plain(c, fin);
				end
				default: begin
					lex = LX_IDLE; ok = plain(c, fin);
				end
			endcase
			if (fin) begin
				if (ok) begin
					if (lex >= LX_WORD) run_word();
					emit(8'h00, depth != 0 ? ST_UNCLOSED : ST_DONE, 1);
				end
				clear();
			end
		endfunction

		function void check_text(text_beat_t got);
			text_beat_t want;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected beat b=%h st=%0d last=%0d", $time,
					got.b, got.st, got.last);
				errors++;
				return;
			end
			want = expected_text.pop_front();
			if (want.b !== got.b) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.b, got.b);
				errors++;
			end
			if (want.st !== got.st) begin
				$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
				errors++;
			end
			if (want.last !== got.last) begin
				$display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, doc_end, out_valid, out_stall, last;
	logic [7:0] in_byte, out_byte;
	logic [2:0] status;

	rtf_text_board board;
	int unsigned idle_pct;
	bit recv_hold;
	int unsigned quiet_cycles;
	int unsigned n_sent;

	rtf_plain_text_extractor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .doc_end(doc_end),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.status(status), .last(last)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	task automatic send_byte(input bit [7:0] c, input bit fin);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_byte <= c;
		doc_end <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_byte(c, fin);
		n_sent++;
	endtask

	task automatic send_doc(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.expected_text.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic string rand_doc();
		string kws[$];
		string s, w;
		int n;
		kws = '{"par", "tab", "ldblquote", "rquote", "bin", "fonttbl", "stylesheet", "xe",
			"foo", "verylongwordx", "info"};
		s = "{";
		n = $urandom_range(2, 9);
		repeat (n) begin
			case ($urandom_range(9))
				0: s = {s, "{"};
				1: s = {s, "}"};
				2: begin
					w = kws[$urandom_range(kws.size() - 1)];
					s = {s, "\\", w};
					if ($urandom_range(1)) s = {s, $sformatf("%0d", $urandom_range(3))};
					if ($urandom_range(2) == 0) s = {s, "-"};
					s = {s, $urandom_range(1) ? " " : "x"};
				end
				3: s = {s, $sformatf("\\'%02h", $urandom_range(255))};
				4: s = {s, "{\\*\\", $urandom_range(1) ? "zz" : "par", " ab}"};
				5: s = {s, "\\", string'(8'($urandom_range(255)))};
				6: s = {s, string'(8'($urandom_range(255)))};
				default: s = {s, string'(8'($urandom_range(32, 126)))};
			endcase
		end
		if ($urandom_range(3) != 0) s = {s, "}"};
		return s;
	endfunction

	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			out_stall <= recv_hold || (idle_pct != 0 && $urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_text({out_byte, status, last});
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("** rtf_plain_text_extractor: FAILED **");
			$finish;
		end
	end

	initial begin
		string s;
		board = new();
		board.clear();
		board.grp_skip = '0;
		idle_pct = 0;
		recv_hold = 0;
		quiet_cycles = 0;
		n_sent = 0;
		arst_n = 0;
		in_valid = 0;
		in_byte = 0;
		doc_end = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		idle_pct = 15;
		send_doc("{a\\par\\'Fe\\bin2 \\{\x00}\\}");
		send_doc("{\\*\\qq x}\\ldblquote\\\n\\\\z}");
		send_doc("{\\fonttbl zz}\\lquote-7 y\\bin");
		send_doc("\\'g1\\'00\x01");
		send_doc("}x\xff");
		send_doc("{{q\\");
		send_doc("\\bin99999999999 \\abcdefghijkl\\*\\tab\r1");
		drain();
		// fill the block while the receiver holds off
		idle_pct = 0;
		recv_hold = 1;
		fork
			begin
				repeat (60) @(posedge clk);
				recv_hold <= 0;
			end
			send_doc("{\\par\\par\\par\\par\\par\\par\\par\\par}");
		join
		s = "";
		repeat (STACK_DEPTH + 1) s = {s, "{"};
		send_doc({s, "x"});
		drain();
		idle_pct = 15;
		while (n_sent < 200) begin
			s = rand_doc();
			send_doc(s);
		end
		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.expected_text.size() == 0)
			$display("** rtf_plain_text_extractor: PASSED **");
		else
			$display("** rtf_plain_text_extractor: FAILED **");
		$finish;
	end
endmodule
